>>> hdl/preg_pkg.sv
// Shared types and codes for the pointer report event generator.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package preg_pkg;

    // Buttons that are checked for changes, counted from bit 0.
    localparam int C_NUM_BUTTONS = 8;
    localparam logic [7:0] C_BUTTON_MASK = 8'((9'd1 << C_NUM_BUTTONS) - 9'd1);

    // Depth of the queue between front end and back end.
    localparam int C_QUEUE_DEPTH = 2;

    // Event kind codes.
    localparam logic [2:0] K_CONNECT    = 3'd0;
    localparam logic [2:0] K_DISCONNECT = 3'd1;
    localparam logic [2:0] K_MOVE       = 3'd2;
    localparam logic [2:0] K_PRESS      = 3'd3;
    localparam logic [2:0] K_RELEASE    = 3'd4;
    localparam logic [2:0] K_SCROLL_V   = 3'd5;
    localparam logic [2:0] K_SCROLL_H   = 3'd6;

    // Events still owed for one poll.
    typedef struct packed {
        logic       conn;
        logic       move;
        logic [7:0] btns;
        logic       sv;
        logic       sh;
    } t_pend;

    // One classified poll, handed from the front end to the back end.
    typedef struct packed {
        logic               link_up;
        t_pend              pend;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic signed [7:0]  wheel_vert;
        logic signed [7:0]  wheel_horiz;
        logic [7:0]         button_map;
        logic [31:0]        stamp;
    } t_job;

endpackage

>>> hdl/preg_channels.sv
// Valid/ready channel interfaces for polls and for events.
// No dependencies.

// Channel that carries one poll of the pointing device per item.
interface preg_poll_if;
    logic               valid;
    logic               ready;
    logic               link_up;
    logic               report_valid;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [7:0]  wheel_vert;
    logic signed [7:0]  wheel_horiz;
    logic [7:0]         button_map;
    logic [31:0]        stamp;

    modport source (
        output valid, link_up, report_valid, move_x, move_y,
               wheel_vert, wheel_horiz, button_map, stamp,
        input  ready
    );
    modport sink (
        input  valid, link_up, report_valid, move_x, move_y,
               wheel_vert, wheel_horiz, button_map, stamp,
        output ready
    );
endinterface

// Channel that carries one pointer event per item.
interface preg_event_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [7:0]  scroll_vert;
    logic signed [7:0]  scroll_horiz;
    logic [2:0]         button_index;
    logic [7:0]         buttons_now;
    logic [31:0]        event_time;
    logic               last_event;

    modport source (
        output valid, event_kind, delta_x, delta_y, scroll_vert, scroll_horiz,
               button_index, buttons_now, event_time, last_event,
        input  ready
    );
    modport sink (
        input  valid, event_kind, delta_x, delta_y, scroll_vert, scroll_horiz,
               button_index, buttons_now, event_time, last_event,
        output ready
    );
endinterface

>>> hdl/preg_front.sv
// Front end: accepts polls, tracks connection and button state, and
// turns each poll into a job of pending events. Depends on preg_pkg.
module preg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    preg_poll_if.sink     i_poll,
    output preg_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import preg_pkg::*;

    logic       r_was_connected;
    logic [7:0] r_prev_buttons;
    logic       accept;
    logic       conn_evt;
    logic       report;
    t_pend      pend;

    // A poll is taken whenever the queue has room.
    assign i_poll.ready = i_job_ready;
    assign accept = i_poll.valid & i_job_ready;

    // Classify the poll into the events it will cause.
    always_comb begin
        conn_evt  = (i_poll.link_up != r_was_connected);
        report    = i_poll.link_up & i_poll.report_valid;
        pend.conn = conn_evt;
        pend.move = report & ((i_poll.move_x != 16'sd0) | (i_poll.move_y != 16'sd0));
        pend.btns = report ? ((i_poll.button_map ^ r_prev_buttons) & C_BUTTON_MASK) : 8'd0;
        pend.sv   = report & (i_poll.wheel_vert != 8'sd0);
        pend.sh   = report & (i_poll.wheel_horiz != 8'sd0);
    end

    // Only polls that cause at least one event go into the queue.
    always_comb begin
        o_job.link_up     = i_poll.link_up;
        o_job.pend        = pend;
        o_job.move_x      = i_poll.move_x;
        o_job.move_y      = i_poll.move_y;
        o_job.wheel_vert  = i_poll.wheel_vert;
        o_job.wheel_horiz = i_poll.wheel_horiz;
        o_job.button_map  = i_poll.button_map;
        o_job.stamp       = i_poll.stamp;
        o_job_valid       = i_poll.valid & (|pend);
    end

    // Remembered connection flag and button bitmap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_connected <= 1'b0;
            r_prev_buttons  <= 8'd0;
        end else if (accept) begin
            r_was_connected <= i_poll.link_up;
            if (report) begin
                r_prev_buttons <= i_poll.button_map;
            end
        end
    end

    a_link_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_was_connected == $past(i_poll.link_up))
        else $error("connection flag not taken from accepted poll");

    a_disc_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && pend.conn && !i_poll.link_up) |->
            !(pend.move || (|pend.btns) || pend.sv || pend.sh))
        else $error("disconnect job carries report events");

    a_valid_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> i_poll.valid)
        else $error("job offered without a poll");

endmodule

>>> hdl/preg_queue.sv
// Small job queue that decouples the front end from the back end.
// Depends on preg_pkg.
module preg_queue #(
    parameter int DEPTH = preg_pkg::C_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  preg_pkg::t_job i_data,
    input  logic           i_push,
    output logic           o_ready,
    output preg_pkg::t_job o_data,
    output logic           o_valid,
    input  logic           i_pop
);
    import preg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue fill level beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue fill level missed a push");

    a_ptr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while empty");

endmodule

>>> hdl/preg_back.sv
// Back end: serializes the events of queued jobs, one per cycle unless
// ready stalls, into a registered output stage. Depends on preg_pkg.
module preg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  preg_pkg::t_job i_job,
    input  logic           i_job_valid,
    output logic           o_job_pop,
    preg_event_if.source   o_event
);
    import preg_pkg::*;

    // Index of the lowest set bit, 0 when none.
    function automatic logic [2:0] lowest_bit(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    t_job               r_job;
    t_pend              r_pend;
    logic               r_busy;
    logic               r_out_valid;
    logic [2:0]         r_kind;
    logic signed [15:0] r_dx;
    logic signed [15:0] r_dy;
    logic signed [7:0]  r_sv;
    logic signed [7:0]  r_sh;
    logic [2:0]         r_idx;
    logic [7:0]         r_btn;
    logic [31:0]        r_time;
    logic               r_last;

    logic               emit;
    logic               load;
    logic               last;
    t_pend              n_pend;
    logic [2:0]         n_kind;
    logic signed [15:0] n_dx;
    logic signed [15:0] n_dy;
    logic signed [7:0]  n_sv;
    logic signed [7:0]  n_sh;
    logic [2:0]         n_idx;
    logic [7:0]         n_btn;
    logic [31:0]        n_time;
    logic [2:0]         bidx;

    // Pick the next pending event in poll order and clear it.
    always_comb begin
        n_pend = r_pend;
        n_kind = K_CONNECT;
        n_dx   = 16'sd0;
        n_dy   = 16'sd0;
        n_sv   = 8'sd0;
        n_sh   = 8'sd0;
        n_idx  = 3'd0;
        n_btn  = r_job.button_map;
        n_time = r_job.stamp;
        bidx   = lowest_bit(r_pend.btns);
        if (r_pend.conn) begin
            n_pend.conn = 1'b0;
            n_kind      = r_job.link_up ? K_CONNECT : K_DISCONNECT;
            n_btn       = 8'd0;
            n_time      = 32'd0;
        end else if (r_pend.move) begin
            n_pend.move = 1'b0;
            n_kind      = K_MOVE;
            n_dx        = r_job.move_x;
            n_dy        = r_job.move_y;
        end else if (|r_pend.btns) begin
            n_pend.btns = r_pend.btns & (r_pend.btns - 8'd1);
            n_kind      = r_job.button_map[bidx] ? K_PRESS : K_RELEASE;
            n_idx       = bidx;
        end else if (r_pend.sv) begin
            n_pend.sv = 1'b0;
            n_kind    = K_SCROLL_V;
            n_sv      = r_job.wheel_vert;
        end else begin
            n_pend.sh = 1'b0;
            n_kind    = K_SCROLL_H;
            n_sh      = r_job.wheel_horiz;
        end
        last = ~(|n_pend);
    end

    // An event moves out when the output stage is free or being drained;
    // a job loads when idle or as the current one emits its last event.
    assign emit      = r_busy & (~r_out_valid | o_event.ready);
    assign load      = i_job_valid & (~r_busy | (emit & last));
    assign o_job_pop = load;

    // Current job and its pending events.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_pend <= i_job.pend;
            r_job  <= i_job;
        end else if (emit) begin
            r_pend <= n_pend;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Output register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
            r_kind      <= n_kind;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_sv        <= n_sv;
            r_sh        <= n_sh;
            r_idx       <= n_idx;
            r_btn       <= n_btn;
            r_time      <= n_time;
            r_last      <= last;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_event.valid        = r_out_valid;
    assign o_event.event_kind   = r_kind;
    assign o_event.delta_x      = r_dx;
    assign o_event.delta_y      = r_dy;
    assign o_event.scroll_vert  = r_sv;
    assign o_event.scroll_horiz = r_sh;
    assign o_event.button_index = r_idx;
    assign o_event.buttons_now  = r_btn;
    assign o_event.event_time   = r_time;
    assign o_event.last_event   = r_last;

    a_busy_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (|r_pend))
        else $error("busy with no pending event");

    a_disc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == K_DISCONNECT) |-> r_last)
        else $error("disconnect event not marked last");

    a_conn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == K_CONNECT || r_kind == K_DISCONNECT)) |->
            (r_time == 32'd0 && r_btn == 8'd0))
        else $error("connection event carries report data");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_busy || last))
        else $error("job loaded over unfinished job");

endmodule

>>> hdl/pointer_report_event_generator.sv
// Pointer report event generator: polls in, pointer events out, each poll
// split into up to twelve events (connection change, move, one per changed
// button from the lowest, vertical and horizontal scroll), the final one of
// a poll marked with last_event. A poll is accepted whenever the two-entry
// job queue has room, also while events of earlier polls are still going
// out. Events leave one per cycle from a registered output stage while the
// consumer holds ready high, the sustained rate being set by the serializer
// in the back end. Events wait, never drop, while the consumer holds ready
// low. Depends on preg_pkg, preg_channels and the submodules.
module pointer_report_event_generator #(
    parameter int QUEUE_DEPTH = preg_pkg::C_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    preg_poll_if.sink     i_poll,
    preg_event_if.source  o_event
);
    import preg_pkg::*;

    t_job job_in;
    t_job job_out;
    logic job_in_valid;
    logic job_in_ready;
    logic job_out_valid;
    logic job_pop;

    // Classification and state tracking.
    preg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_poll      (i_poll),
        .o_job       (job_in),
        .o_job_valid (job_in_valid),
        .i_job_ready (job_in_ready)
    );

    // Decoupling queue.
    preg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (job_in),
        .i_push  (job_in_valid),
        .o_ready (job_in_ready),
        .o_data  (job_out),
        .o_valid (job_out_valid),
        .i_pop   (job_pop)
    );

    // Event serializer.
    preg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_valid (job_out_valid),
        .o_job_pop   (job_pop),
        .o_event     (o_event)
    );

endmodule
